// ===== src/tacf_pkg.sv =====
// Shared types, register indexes and arithmetic constants of the two-axis complementary filter.
package tacf_pkg;

   localparam int DATA_W     = 16;
   localparam int GAIN_W     = 7;
   localparam int ST_W       = 10;
   localparam int CLIP_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // shared multiplier: magnitude operand, constant/gain operand, product
   localparam int MUL_A_W = 29;
   localparam int MUL_B_W = 30;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int MAG_W   = 23;
   localparam int INNER_W = MAG_W + 1;
   localparam int HPT_W   = MAG_W + 1;
   localparam int SUM_W   = MUL_A_W + 2;
   localparam int LP100_W = 14;

   // reciprocal constants: floor(m / d) == (m * C) >> SHIFT for the magnitude ranges used
   localparam int                 C10_SHIFT  = 28;
   localparam logic [MUL_B_W-1:0] C10_RECIP  = 30'd26843546;
   localparam int                 C100_SHIFT = 36;
   localparam logic [MUL_B_W-1:0] C100_RECIP = 30'd687194768;
   localparam logic [LP100_W-1:0] LP_SCALE   = 14'd100;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

   localparam logic [CLIP_W-1:0] CLIP_NONE = 2'd0;
   localparam logic [CLIP_W-1:0] CLIP_HIGH = 2'd1;
   localparam logic [CLIP_W-1:0] CLIP_LOW  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_LP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_HP_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_LP_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_HP_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_TIME   = 3'd4;

   localparam logic [GAIN_W-1:0] LP_GAIN_RESET     = 7'd2;
   localparam logic [GAIN_W-1:0] HP_GAIN_RESET     = 7'd98;
   localparam logic [ST_W-1:0]   SAMPLE_TIME_RESET = 10'd1;

   typedef struct packed {
      logic signed [DATA_W-1:0] accel_x;
      logic signed [DATA_W-1:0] accel_y;
      logic signed [DATA_W-1:0] rate_roll;
      logic signed [DATA_W-1:0] rate_pitch;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] angle_roll;
      logic signed [DATA_W-1:0] angle_pitch;
      logic [CLIP_W-1:0]        clip_roll;
      logic [CLIP_W-1:0]        clip_pitch;
   } rsp_type;

   typedef enum logic [3:0] {
      LS_IDLE,
      LS_RATE,
      LS_DIV10,
      LS_INNER,
      LS_HP,
      LS_DIV100,
      LS_LP,
      LS_DIVG,
      LS_SUM,
      LS_DONE
   } lane_state_type;

   typedef struct packed {
      logic                     ready;
      logic                     done;
      logic signed [DATA_W-1:0] angle;
      logic [CLIP_W-1:0]        clip;
   } lane_out_type;

endpackage

// ===== src/two_axis_complementary_filter_top.sv =====
// Top level of the two-axis complementary filter: control registers, two axis lanes, merge.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (accel x/y, roll/pitch rate)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (roll/pitch angle, clip flags)
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// Each lane runs eight sequencer steps on its one multiplier; a new transaction is taken only
// while both lanes are idle or are handing their finished results to the registered response.
// Synchronous reset loads the default gains and sample time and zeroes both angles.
// A stalled rsp holds the finished lanes; req_ready stays low until they hand over.
// csr writes are taken in every cycle.
module two_axis_complementary_filter_top #(
   parameter int GRAVITY_SCALE = 98
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tacf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tacf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tacf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tacf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tacf_pkg::*;

   logic [GAIN_W-1:0] roll_lp_ff, roll_lp_in;
   logic [GAIN_W-1:0] roll_hp_ff, roll_hp_in;
   logic [GAIN_W-1:0] pitch_lp_ff, pitch_lp_in;
   logic [GAIN_W-1:0] pitch_hp_ff, pitch_hp_in;
   logic [ST_W-1:0]   sample_time_ff, sample_time_in;

   logic signed [DATA_W-1:0] roll_accel;
   logic                     start;
   logic                     take;
   lane_out_type             roll_out;
   lane_out_type             pitch_out;

   assign csr_ready = 1'b1;

   always_comb begin
      roll_lp_in     = roll_lp_ff;
      roll_hp_in     = roll_hp_ff;
      pitch_lp_in    = pitch_lp_ff;
      pitch_hp_in    = pitch_hp_ff;
      sample_time_in = sample_time_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROLL_LP_GAIN:  roll_lp_in     = csr_wdata[GAIN_W-1:0];
            CSR_ROLL_HP_GAIN:  roll_hp_in     = csr_wdata[GAIN_W-1:0];
            CSR_PITCH_LP_GAIN: pitch_lp_in    = csr_wdata[GAIN_W-1:0];
            CSR_PITCH_HP_GAIN: pitch_hp_in    = csr_wdata[GAIN_W-1:0];
            CSR_SAMPLE_TIME:   sample_time_in = csr_wdata[ST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_lp_ff     <= LP_GAIN_RESET;
         roll_hp_ff     <= HP_GAIN_RESET;
         pitch_lp_ff    <= LP_GAIN_RESET;
         pitch_hp_ff    <= HP_GAIN_RESET;
         sample_time_ff <= SAMPLE_TIME_RESET;
      end else begin
         roll_lp_ff     <= roll_lp_in;
         roll_hp_ff     <= roll_hp_in;
         pitch_lp_ff    <= pitch_lp_in;
         pitch_hp_ff    <= pitch_hp_in;
         sample_time_ff <= sample_time_in;
      end
   end

   // negate Y for roll, saturating the most negative code
   assign roll_accel = (req_data.accel_y == SAT_MIN) ? SAT_MAX : -req_data.accel_y;

   assign req_ready = roll_out.ready && pitch_out.ready;
   assign start     = req_valid && req_ready;

   tacf_lane #(
      .GRAVITY_SCALE (GRAVITY_SCALE)
   ) u_roll_lane (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .take        (take),
      .accel       (roll_accel),
      .rate        (req_data.rate_roll),
      .lp_gain     (roll_lp_ff),
      .hp_gain     (roll_hp_ff),
      .sample_time (sample_time_ff),
      .lane_out    (roll_out)
   );

   tacf_lane #(
      .GRAVITY_SCALE (GRAVITY_SCALE)
   ) u_pitch_lane (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .take        (take),
      .accel       (req_data.accel_x),
      .rate        (req_data.rate_pitch),
      .lp_gain     (pitch_lp_ff),
      .hp_gain     (pitch_hp_ff),
      .sample_time (sample_time_ff),
      .lane_out    (pitch_out)
   );

   tacf_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .roll_out  (roll_out),
      .pitch_out (pitch_out),
      .rsp_ready (rsp_ready),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (roll_out.done == pitch_out.done) && (roll_out.ready == pitch_out.ready))
      else $error("axis lanes out of step");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("lanes ready again right after a transaction");

   a_take_fills_output: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("lane handoff did not produce a response");

endmodule

// ===== src/tacf_lane.sv =====
// One axis lane: eight-step sequencer around a shared multiplier, holds the axis angle.
module tacf_lane #(
   parameter int GRAVITY_SCALE = 98
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                take,
   input  logic signed [tacf_pkg::DATA_W-1:0]  accel,
   input  logic signed [tacf_pkg::DATA_W-1:0]  rate,
   input  logic [tacf_pkg::GAIN_W-1:0]         lp_gain,
   input  logic [tacf_pkg::GAIN_W-1:0]         hp_gain,
   input  logic [tacf_pkg::ST_W-1:0]           sample_time,
   output tacf_pkg::lane_out_type              lane_out
);
   import tacf_pkg::*;

   localparam int GS_SHIFT = MUL_A_W + $clog2(GRAVITY_SCALE);
   localparam logic [63:0] GS_RECIP_WIDE =
      ((64'd1 << GS_SHIFT) + 64'(GRAVITY_SCALE) - 64'd1) / 64'(GRAVITY_SCALE);
   localparam logic [MUL_B_W-1:0] GS_RECIP = GS_RECIP_WIDE[MUL_B_W-1:0];

   lane_state_type state_ff, state_in;

   logic signed [DATA_W-1:0] accel_ff, accel_in;
   logic signed [DATA_W-1:0] rate_ff, rate_in;
   logic [LP100_W-1:0]       lp100_ff, lp100_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     sign_ff, sign_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic signed [HPT_W-1:0]  hpt_ff, hpt_in;
   logic signed [DATA_W-1:0] angle_ff, angle_in;
   logic [CLIP_W-1:0]        clip_ff, clip_in;

   logic [MUL_A_W-1:0]        mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic [DATA_W-1:0]         rate_mag;
   logic [DATA_W-1:0]         accel_mag;
   logic [MAG_W-1:0]          quot10;
   logic [MAG_W-1:0]          quot100;
   logic signed [INNER_W-1:0] inner;
   logic signed [INNER_W-1:0] inner_abs;
   logic [PROD_W-1:0]         lp_shift;
   logic signed [SUM_W-1:0]   lpt;
   logic signed [SUM_W-1:0]   sum;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LS_IDLE:   if (start) state_in = LS_RATE;
         LS_RATE:   state_in = LS_DIV10;
         LS_DIV10:  state_in = LS_INNER;
         LS_INNER:  state_in = LS_HP;
         LS_HP:     state_in = LS_DIV100;
         LS_DIV100: state_in = LS_LP;
         LS_LP:     state_in = LS_DIVG;
         LS_DIVG:   state_in = LS_SUM;
         LS_SUM:    state_in = LS_DONE;
         LS_DONE: begin
            if (start) state_in = LS_RATE;
            else if (take) state_in = LS_IDLE;
         end
         default:   state_in = LS_IDLE;
      endcase
   end

   always_comb begin
      accel_in = accel_ff;
      rate_in  = rate_ff;
      lp100_in = lp100_ff;
      sign_in  = sign_ff;
      mag_in   = mag_ff;
      hpt_in   = hpt_ff;
      angle_in = angle_ff;
      clip_in  = clip_ff;
      mul_a    = '0;
      mul_b    = '0;

      rate_mag  = rate_ff[DATA_W-1] ? DATA_W'(-rate_ff) : DATA_W'(rate_ff);
      accel_mag = accel_ff[DATA_W-1] ? DATA_W'(-accel_ff) : DATA_W'(accel_ff);
      quot10    = prod_ff[C10_SHIFT +: MAG_W];
      quot100   = prod_ff[C100_SHIFT +: MAG_W];
      inner     = (sign_ff ? -$signed({1'b0, quot10}) : $signed({1'b0, quot10}))
                  + INNER_W'(angle_ff);
      inner_abs = inner[INNER_W-1] ? -inner : inner;
      lp_shift  = prod_ff >> GS_SHIFT;
      lpt       = sign_ff ? -$signed({2'b0, lp_shift[MUL_A_W-1:0]})
                          :  $signed({2'b0, lp_shift[MUL_A_W-1:0]});
      sum       = SUM_W'(hpt_ff) + lpt;

      lane_out.ready = (state_ff == LS_IDLE) || ((state_ff == LS_DONE) && take);
      lane_out.done  = (state_ff == LS_DONE);
      lane_out.angle = angle_ff;
      lane_out.clip  = clip_ff;

      if (start) begin
         accel_in = accel;
         rate_in  = rate;
      end

      case (state_ff)
         LS_RATE: begin
            mul_a    = MUL_A_W'(rate_mag);
            mul_b    = MUL_B_W'(sample_time);
            sign_in  = rate_ff[DATA_W-1];
            lp100_in = LP100_W'(lp_gain) * LP_SCALE;
         end
         LS_DIV10: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = C10_RECIP;
         end
         LS_INNER: begin
            sign_in = inner[INNER_W-1];
            mag_in  = inner_abs[MAG_W-1:0];
         end
         LS_HP: begin
            mul_a = MUL_A_W'(mag_ff);
            mul_b = MUL_B_W'(hp_gain);
         end
         LS_DIV100: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = C100_RECIP;
         end
         LS_LP: begin
            hpt_in  = sign_ff ? -$signed({1'b0, quot100}) : $signed({1'b0, quot100});
            mul_a   = MUL_A_W'(accel_mag);
            mul_b   = MUL_B_W'(lp100_ff);
            sign_in = accel_ff[DATA_W-1];
         end
         LS_DIVG: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = GS_RECIP;
         end
         LS_SUM: begin
            if (sum > SUM_W'(SAT_MAX)) begin
               angle_in = SAT_MAX;
               clip_in  = CLIP_HIGH;
            end else if (sum < SUM_W'(SAT_MIN)) begin
               angle_in = SAT_MIN;
               clip_in  = CLIP_LOW;
            end else begin
               angle_in = sum[DATA_W-1:0];
               clip_in  = CLIP_NONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
         angle_ff <= '0;
         clip_ff  <= CLIP_NONE;
      end else begin
         state_ff <= state_in;
         angle_ff <= angle_in;
         clip_ff  <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      accel_ff <= accel_in;
      rate_ff  <= rate_in;
      lp100_ff <= lp100_in;
      prod_ff  <= prod_in;
      sign_ff  <= sign_in;
      mag_ff   <= mag_in;
      hpt_ff   <= hpt_in;
   end

endmodule

// ===== src/tacf_merge.sv =====
// Merge stage: joins both lane results into the registered response transaction.
module tacf_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  tacf_pkg::lane_out_type  roll_out,
   input  tacf_pkg::lane_out_type  pitch_out,
   input  logic                    rsp_ready,
   output logic                    take,
   output logic                    rsp_valid,
   output tacf_pkg::rsp_type       rsp_data
);
   import tacf_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      take         = roll_out.done && pitch_out.done && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.angle_roll  = roll_out.angle;
         rsp_data_in.angle_pitch = pitch_out.angle;
         rsp_data_in.clip_roll   = roll_out.clip;
         rsp_data_in.clip_pitch  = pitch_out.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
